// ----- design/wpd_pkg.sv -----
// shared widths and payload types for the window partition datapath
`timescale 1ns / 1ps

package wpd_pkg;

  localparam int unsigned OFFSET_BITS   = 6;
  localparam int unsigned IO_SCORE_BITS = 32;

  typedef logic [OFFSET_BITS-1:0]          offset_t;
  typedef logic signed [IO_SCORE_BITS-1:0] io_score_t;

endpackage

// ----- design/wpd_if.sv -----
// candidate and result channel interfaces
`timescale 1ns / 1ps

interface wpd_in_if;
  import wpd_pkg::*;

  logic      valid;
  logic      ready;
  logic      new_sequence;
  offset_t   end_offset;
  io_score_t window_score;
  logic      reaches_end;
  logic      last_candidate;

  modport source (
    output valid, new_sequence, end_offset, window_score, reaches_end, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, new_sequence, end_offset, window_score, reaches_end, last_candidate,
    output ready
  );
endinterface

interface wpd_out_if;
  import wpd_pkg::*;

  logic      valid;
  logic      ready;
  io_score_t best_score;
  offset_t   best_offset;
  logic      missing_score;

  modport source (
    output valid, best_score, best_offset, missing_score,
    input  ready
  );
  modport sink (
    input  valid, best_score, best_offset, missing_score,
    output ready
  );
endinterface

// ----- design/wpd_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module wpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/window_partition_dp.sv -----
// window partition dynamic programming datapath, top level
//
// in_i carries one candidate window per transfer: end offset, window score,
// a flag for windows that reach the sequence end, a first-of-sequence flag
// and a last-candidate flag. A last candidate produces one result on out_o:
// best score, end offset of the best window and a flag for candidates whose
// downstream optimum was never computed.
// One candidate is taken per cycle while in_i.ready is high. Stage 0 reads
// the optimum store (one read port, registered read), stage 1 adds, compares
// and, on the last candidate, writes the best score back and loads the output
// register, from which the result is presented on out_o. Back to back reads
// of an entry that stage 1 is writing are served by a forwarding register.
// While a result waits in the output register and out_o.ready is low, a
// further last candidate holds in stage 1 and in_i.ready drops; other
// candidates keep flowing. Reset empties the pipeline and the fill count;
// store contents need no clearing since unfilled entries are never used.
`timescale 1ns / 1ps

module window_partition_dp #(
  parameter int unsigned WINDOW_SPAN = 64,
  parameter int unsigned SCORE_BITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wpd_in_if.sink        in_i,
  wpd_out_if.source     out_o
);
  import wpd_pkg::*;

  localparam int unsigned AW   = (WINDOW_SPAN > 1) ? $clog2(WINDOW_SPAN) : 1;
  localparam int unsigned FW   = $clog2(WINDOW_SPAN + 1);
  localparam int unsigned CW   = (FW > OFFSET_BITS) ? FW : OFFSET_BITS;
  localparam int unsigned SUMW = ((AW > OFFSET_BITS) ? AW : OFFSET_BITS) + 1;
  localparam int unsigned SW   = SCORE_BITS;

  localparam logic signed [63:0] SMAX64 = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN64 = -SMAX64 - 64'sd1;
  localparam logic signed [SW-1:0] SMAX = SMAX64[SW-1:0];
  localparam logic signed [SW-1:0] SMIN = SMIN64[SW-1:0];

  // control state
  logic [AW-1:0] head_q, head_d, head_dec;
  logic [FW-1:0] filled_q, filled_d, filled_eff;

  // stage 1
  logic              s1_valid_q, s1_valid_d;
  logic              s1_new_q, s1_last_q, s1_end_q, s1_rdok_q, s1_fwd_q;
  offset_t           s1_offset_q;
  logic signed [SW-1:0] s1_ws_q;
  logic [AW-1:0]     s1_waddr_q;
  logic signed [SW-1:0] fwd_data_q;

  // running accumulators
  logic signed [SW-1:0] run_best_q, run_best_d;
  offset_t              run_offset_q, run_offset_d;
  logic                 run_err_q, run_err_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_score_q;
  offset_t              out_offset_q;
  logic                 out_err_q;

  logic                 accept, stall, s1_fire, s1_write;
  logic                 rd_ok, fwd_hit;
  logic [SUMW-1:0]      idx_sum, idx_wrap;
  logic [AW-1:0]        rd_idx;
  logic signed [63:0]   ws64;
  logic signed [SW-1:0] ws_clamped;
  logic [SW-1:0]        ram_rdata;
  logic signed [SW-1:0] opt_val, cand;
  logic signed [SW:0]   sat_sum;
  logic signed [SW-1:0] base_best;
  offset_t              base_offset;
  logic                 base_err;
  logic signed [63:0]   best_ext;

  assign stall   = s1_valid_q && s1_last_q && out_valid_q && !out_o.ready;
  assign accept  = in_i.valid && in_i.ready;
  assign s1_fire = s1_valid_q && !stall;
  assign s1_write = s1_fire && s1_last_q;
  assign in_i.ready = !stall;

  // stage 0: address and fill check
  always_comb begin
    filled_eff = in_i.new_sequence ? '0 : filled_q;
    rd_ok      = !in_i.reaches_end &&
                 (CW'(in_i.end_offset) < CW'(filled_eff));
    idx_sum    = SUMW'(head_q) + SUMW'(in_i.end_offset);
    idx_wrap   = (idx_sum >= SUMW'(WINDOW_SPAN)) ? idx_sum - SUMW'(WINDOW_SPAN) : idx_sum;
    rd_idx     = idx_wrap[AW-1:0];
    head_dec   = (head_q == '0) ? AW'(WINDOW_SPAN - 1) : head_q - AW'(1);
    fwd_hit    = s1_write && rd_ok && (rd_idx == s1_waddr_q);

    ws64 = 64'(in_i.window_score);
    if (ws64 > SMAX64) begin
      ws_clamped = SMAX;
    end else if (ws64 < SMIN64) begin
      ws_clamped = SMIN;
    end else begin
      ws_clamped = ws64[SW-1:0];
    end

    head_d   = head_q;
    filled_d = filled_q;
    if (accept) begin
      filled_d = filled_eff;
      if (in_i.last_candidate) begin
        head_d   = head_dec;
        filled_d = (filled_eff == FW'(WINDOW_SPAN)) ? filled_eff : filled_eff + FW'(1);
      end
    end
  end

  wpd_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_SPAN)
  ) u_opt_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_waddr_q),
    .wdata_i (run_best_d),
    .re_i    (accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // stage 1: saturating add, first strict maximum
  always_comb begin
    opt_val = s1_fwd_q ? fwd_data_q : $signed(ram_rdata);
    sat_sum = {opt_val[SW-1], opt_val} + {s1_ws_q[SW-1], s1_ws_q};

    base_best   = s1_new_q ? SMIN : run_best_q;
    base_offset = s1_new_q ? '0 : run_offset_q;
    base_err    = s1_new_q ? 1'b0 : run_err_q;

    run_err_d = base_err;
    if (s1_end_q) begin
      cand = s1_ws_q;
    end else if (s1_rdok_q) begin
      if (sat_sum[SW] != sat_sum[SW-1]) begin
        cand = sat_sum[SW] ? SMIN : SMAX;
      end else begin
        cand = sat_sum[SW-1:0];
      end
    end else begin
      cand      = '0;
      run_err_d = 1'b1;
    end

    if (cand > base_best) begin
      run_best_d   = cand;
      run_offset_d = s1_offset_q;
    end else begin
      run_best_d   = base_best;
      run_offset_d = base_offset;
    end

    s1_valid_d = accept || stall;

    out_valid_d = out_valid_q && !out_o.ready;
    if (s1_write) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      filled_q     <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      run_best_q   <= SMIN;
      run_offset_q <= '0;
      run_err_q    <= 1'b0;
    end else begin
      head_q      <= head_d;
      filled_q    <= filled_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        if (s1_last_q) begin
          run_best_q   <= SMIN;
          run_offset_q <= '0;
          run_err_q    <= 1'b0;
        end else begin
          run_best_q   <= run_best_d;
          run_offset_q <= run_offset_d;
          run_err_q    <= run_err_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_new_q    <= in_i.new_sequence;
      s1_last_q   <= in_i.last_candidate;
      s1_end_q    <= in_i.reaches_end;
      s1_rdok_q   <= rd_ok;
      s1_fwd_q    <= fwd_hit;
      s1_offset_q <= in_i.end_offset;
      s1_ws_q     <= ws_clamped;
      s1_waddr_q  <= head_dec;
      fwd_data_q  <= run_best_d;
    end
    if (s1_write) begin
      out_score_q  <= run_best_d;
      out_offset_q <= run_offset_d;
      out_err_q    <= run_err_d;
    end
  end

  assign best_ext            = 64'(out_score_q);
  assign out_o.valid         = out_valid_q;
  assign out_o.best_score    = best_ext[IO_SCORE_BITS-1:0];
  assign out_o.best_offset   = out_offset_q;
  assign out_o.missing_score = out_err_q;

endmodule

// ----- design/wpd_checker.sv -----
// port-level checks for the window partition datapath
`timescale 1ns / 1ps

module wpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_new_i,
  input logic [5:0]  in_offset_i,
  input logic        in_end_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_score_i,
  input logic [5:0]  out_offset_i,
  input logic        out_missing_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_score_i) && $stable(out_offset_i)
      && $stable(out_missing_i))
    else $error("result changed while stalled");

  // a last candidate yields a result on out_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_last_i |=> ##1 out_valid_i)
    else $error("no result after last candidate");

  // a lone candidate at the start of a sequence has no stored optimum
  a_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_new_i && in_last_i && !in_end_i) ##1 (!out_valid_i || out_ready_i)
      |=> out_valid_i && out_missing_i && (out_score_i == 32'd0)
        && (out_offset_i == $past(in_offset_i, 2)))
    else $error("missing optimum not flagged");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind window_partition_dp wpd_checker u_wpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_new_i      (in_i.new_sequence),
  .in_offset_i   (in_i.end_offset),
  .in_end_i      (in_i.reaches_end),
  .in_last_i     (in_i.last_candidate),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_score_i   (out_o.best_score),
  .out_offset_i  (out_o.best_offset),
  .out_missing_i (out_o.missing_score)
);
